// File: hw/rtl/stable_priority_queue_top_defines.svh
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned SpqDepth    = 16;
  localparam int unsigned SpqPrioBits = 8;
  localparam int unsigned SpqTagBits  = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  // Step command broadcast along the row
  typedef struct packed {
    logic ins;   // insert that fits
    logic rem;   // remove from a non-empty queue
  } spq_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/stable_priority_queue_top.sv
// Throughput: one request per cycle while the result slot is free or being
//   drained; every cell of the row compares and shifts in the same cycle, so
//   no request waits on the one before it. All result outputs are registered.
// Reset (rst_ni low, asynchronous): queue empty, no result pending.
//   The slot store itself is not cleared; only slots below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top #(
  parameter int unsigned DEPTH     = spq_pkg::SpqDepth,
  parameter int unsigned PRIO_BITS = spq_pkg::SpqPrioBits,
  parameter int unsigned TAG_BITS  = spq_pkg::SpqTagBits,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // request side
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   op_i,
  input  wire  [PRIO_BITS-1:0]  priority_req_i,
  input  wire  [TAG_BITS-1:0]   tag_i,
  // result side
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  removed_valid_o,
  output logic [PRIO_BITS-1:0]  removed_priority_o,
  output logic [TAG_BITS-1:0]   removed_tag_o,
  output logic                  head_valid_o,
  output logic [PRIO_BITS-1:0]  head_priority_o,
  output logic [TAG_BITS-1:0]   head_tag_o,
  output logic [CntW-1:0]       count_o,
  output logic                  overflow_o
);
  import spq_pkg::*;

  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // Occupancy
  logic [CntW-1:0] fill_q, fill_d;

  // Result register
  logic                 out_valid_q;
  logic                 rem_valid_q, head_valid_q, ovf_q;
  logic [PRIO_BITS-1:0] rem_prio_q, head_prio_q;
  logic [TAG_BITS-1:0]  rem_tag_q, head_tag_q;
  logic [CntW-1:0]      cnt_q;

  // Row wiring
  logic [DEPTH-1:0]     keep;
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag  [DEPTH];

  logic      req_fire, is_ins, full, empty;
  spq_ctrl_t ctrl;

  // A new request is taken whenever the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign req_fire   = in_valid_i && in_ready_o;
  assign is_ins     = (spq_op_e'(op_i) == OP_INSERT);
  assign full       = (fill_q == FullCnt);
  assign empty      = (fill_q == '0);

  assign ctrl.ins = req_fire && is_ins && !full;
  assign ctrl.rem = req_fire && !is_ins && !empty;

  always_comb begin
    fill_d = fill_q;
    if (ctrl.ins) begin
      fill_d = fill_q + CntW'(1);
    end else if (ctrl.rem) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  // Cell row: slot 0 is the head. Each cell looks only at its neighbours.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 lkeep;
    logic [PRIO_BITS-1:0] lprio, rprio;
    logic [TAG_BITS-1:0]  ltag, rtag;

    if (g == 0) begin : g_first
      // nothing ahead of the head, so a newcomer that beats it lands here
      assign lkeep = 1'b1;
      assign lprio = cell_prio[g];
      assign ltag  = cell_tag[g];
    end else begin : g_mid
      assign lkeep = keep[g-1];
      assign lprio = cell_prio[g-1];
      assign ltag  = cell_tag[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rprio = cell_prio[g];
      assign rtag  = cell_tag[g];
    end else begin : g_inner
      assign rprio = cell_prio[g+1];
      assign rtag  = cell_tag[g+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CntW'(g) < fill_q),
      .new_prio_i   (priority_req_i),
      .new_tag_i    (tag_i),
      .left_keep_i  (lkeep),
      .left_prio_i  (lprio),
      .left_tag_i   (ltag),
      .right_prio_i (rprio),
      .right_tag_i  (rtag),
      .keep_o       (keep[g]),
      .prio_o       (cell_prio[g]),
      .tag_o        (cell_tag[g])
    );
  end

  // Head after the step, worked out from the current row
  logic                 nhead_valid;
  logic [PRIO_BITS-1:0] nhead_prio;
  logic [TAG_BITS-1:0]  nhead_tag;

  always_comb begin
    nhead_valid = (fill_d != '0);
    nhead_prio  = cell_prio[0];
    nhead_tag   = cell_tag[0];
    if (ctrl.ins && !keep[0]) begin
      nhead_prio = priority_req_i;
      nhead_tag  = tag_i;
    end else if (ctrl.rem) begin
      nhead_prio = cell_prio[1];
      nhead_tag  = cell_tag[1];
    end
    if (!nhead_valid) begin
      nhead_prio = '0;
      nhead_tag  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (req_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted request
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rem_valid_q  <= ctrl.rem;
      rem_prio_q   <= ctrl.rem ? cell_prio[0] : '0;
      rem_tag_q    <= ctrl.rem ? cell_tag[0]  : '0;
      head_valid_q <= nhead_valid;
      head_prio_q  <= nhead_prio;
      head_tag_q   <= nhead_tag;
      cnt_q        <= fill_d;
      ovf_q        <= is_ins && full;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign removed_valid_o    = rem_valid_q;
  assign removed_priority_o = rem_prio_q;
  assign removed_tag_o      = rem_tag_q;
  assign head_valid_o       = head_valid_q;
  assign head_priority_o    = head_prio_q;
  assign head_tag_o         = head_tag_q;
  assign count_o            = cnt_q;
  assign overflow_o         = ovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int unsigned PRIO_BITS = 8,
  parameter int unsigned TAG_BITS  = 16
) (
  input  wire                     clk_i,
  input  wire spq_pkg::spq_ctrl_t ctrl_i,
  input  wire                     occupied_i,
  input  wire  [PRIO_BITS-1:0]    new_prio_i,
  input  wire  [TAG_BITS-1:0]     new_tag_i,
  input  wire                     left_keep_i,
  input  wire  [PRIO_BITS-1:0]    left_prio_i,
  input  wire  [TAG_BITS-1:0]     left_tag_i,
  input  wire  [PRIO_BITS-1:0]    right_prio_i,
  input  wire  [TAG_BITS-1:0]     right_tag_i,
  output logic                    keep_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic [TAG_BITS-1:0]     tag_o
);
  import spq_pkg::*;

  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;

  // Held entry outranks or ties the newcomer: it stays put (ties keep FIFO order)
  assign keep_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end else begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end
    end else if (ctrl_i.rem) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

// File: hw/rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stable_priority_queue_top_defines.svh"

module spq_checker #(
  parameter int unsigned DEPTH     = spq_pkg::SpqDepth,
  parameter int unsigned PRIO_BITS = spq_pkg::SpqPrioBits,
  parameter int unsigned TAG_BITS  = spq_pkg::SpqTagBits,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wire                  removed_valid_o,
  input wire [PRIO_BITS-1:0]  removed_priority_o,
  input wire [TAG_BITS-1:0]   removed_tag_o,
  input wire                  head_valid_o,
  input wire [PRIO_BITS-1:0]  head_priority_o,
  input wire [CntW-1:0]       count_o
);
  import spq_pkg::*;

  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  `SPQ_ASSERT_NOW(a_count_range, out_valid_o, count_o <= FullCnt)
  `SPQ_ASSERT_NOW(a_head_vs_count, out_valid_o, head_valid_o == (count_o != '0))
  `SPQ_ASSERT_NOW(a_sorted_order, out_valid_o && removed_valid_o && head_valid_o,
                  head_priority_o <= removed_priority_o)
  `SPQ_ASSERT_NOW(a_empty_remove_zero, out_valid_o && !removed_valid_o,
                  (removed_priority_o == '0) && (removed_tag_o == '0))
  `SPQ_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind stable_priority_queue_top spq_checker #(
  .DEPTH     (DEPTH),
  .PRIO_BITS (PRIO_BITS),
  .TAG_BITS  (TAG_BITS)
) u_spq_checker (.*);

`default_nettype wire

// File: tb/spq_order_checker.sv
`timescale 1ns / 1ps

module spq_order_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  wire        op_i,
  input  wire [7:0]  priority_req_i,
  input  wire [15:0] tag_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  wire        removed_valid_i,
  input  wire [7:0]  removed_priority_i,
  input  wire [15:0] removed_tag_i,
  input  wire        head_valid_i,
  input  wire [7:0]  head_priority_i,
  input  wire [15:0] head_tag_i,
  input  wire [4:0]  count_i,
  input  wire        overflow_i,
  output int         errors_o,
  output int         outstanding_o
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(SpqDepth + 1);

  typedef struct packed {
    logic                   removed_valid;
    logic [SpqPrioBits-1:0] removed_priority;
    logic [SpqTagBits-1:0]  removed_tag;
    logic                   head_valid;
    logic [SpqPrioBits-1:0] head_priority;
    logic [SpqTagBits-1:0]  head_tag;
    logic [CountW-1:0]      count;
    logic                   overflow;
  } spq_result_t;

  // Mirror of the sorted store: slot 0 is the highest priority.
  logic [SpqPrioBits-1:0] held_prio [SpqDepth];
  logic [SpqTagBits-1:0]  held_tag  [SpqDepth];
  int unsigned            held_count;

  spq_result_t due_results [$];
  int          result_no;

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    held_count    = 0;
    result_no     = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d %s: got %0h, expected %0h", $time, result_no, what, got, want);
    errors_o++;
  endtask

  // Applies one request to the mirror and returns the result it should give.
  function automatic spq_result_t next_queue_result(input spq_op_e kind,
                                                     input logic [SpqPrioBits-1:0] prio,
                                                     input logic [SpqTagBits-1:0] tg);
    spq_result_t r;
    int unsigned pos;
    r = '0;
    if (kind == OP_INSERT) begin
      if (held_count >= SpqDepth) begin
        r.overflow = 1'b1;
      end else begin
        // ties go behind entries already held
        pos = 0;
        while (pos < held_count && held_prio[pos] >= prio) pos++;
        for (int unsigned i = held_count; i > pos; i--) begin
          held_prio[i] = held_prio[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_prio[pos] = prio;
        held_tag[pos]  = tg;
        held_count++;
      end
    end else if (held_count > 0) begin
      r.removed_valid    = 1'b1;
      r.removed_priority = held_prio[0];
      r.removed_tag      = held_tag[0];
      for (int unsigned i = 0; i + 1 < held_count; i++) begin
        held_prio[i] = held_prio[i+1];
        held_tag[i]  = held_tag[i+1];
      end
      held_count--;
    end
    if (held_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_priority = held_prio[0];
      r.head_tag      = held_tag[0];
    end
    r.count = CountW'(held_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      due_results.delete();
      outstanding_o = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        due_results.push_back(next_queue_result(spq_op_e'(op_i), priority_req_i, tag_i));
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("with nothing outstanding", 32'(count_i), 0);
        end else begin
          want = due_results.pop_front();
          if (removed_valid_i !== want.removed_valid)
            report_mismatch("removed_valid", 32'(removed_valid_i), 32'(want.removed_valid));
          if (removed_priority_i !== want.removed_priority)
            report_mismatch("removed_priority", 32'(removed_priority_i),
                            32'(want.removed_priority));
          if (removed_tag_i !== want.removed_tag)
            report_mismatch("removed_tag", 32'(removed_tag_i), 32'(want.removed_tag));
          if (head_valid_i !== want.head_valid)
            report_mismatch("head_valid", 32'(head_valid_i), 32'(want.head_valid));
          if (head_priority_i !== want.head_priority)
            report_mismatch("head_priority", 32'(head_priority_i), 32'(want.head_priority));
          if (head_tag_i !== want.head_tag)
            report_mismatch("head_tag", 32'(head_tag_i), 32'(want.head_tag));
          if (count_i !== want.count)
            report_mismatch("count", 32'(count_i), 32'(want.count));
          if (overflow_i !== want.overflow)
            report_mismatch("overflow", 32'(overflow_i), 32'(want.overflow));
        end
        result_no++;
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the stable priority queue. The checker beside the
// block watches both channels, keeps its own sorted mirror and compares every
// result; this module only makes requests, paces the receiver and decides.
module tb_top;
  import spq_pkg::*;

  localparam int unsigned CountW         = $clog2(SpqDepth + 1);
  localparam int          WatchdogLimit  = 5000;
  localparam int          RandomPerPhase = 250;

  logic clk;
  logic rst_n;

  // request side
  logic                   req_valid;
  logic                   in_ready;
  spq_op_e                req_op;
  logic [SpqPrioBits-1:0] req_prio;
  logic [SpqTagBits-1:0]  req_tag;

  // result side
  logic                   out_valid;
  logic                   out_ready;
  logic                   removed_valid;
  logic [SpqPrioBits-1:0] removed_priority;
  logic [SpqTagBits-1:0]  removed_tag;
  logic                   head_valid;
  logic [SpqPrioBits-1:0] head_priority;
  logic [SpqTagBits-1:0]  head_tag;
  logic [CountW-1:0]      count;
  logic                   overflow;

  int errors;
  int outstanding;

  // idle odds in percent, changed per phase
  int send_idle_pct;
  int recv_stall_pct;

  int stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stable_priority_queue_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_ready_o         (in_ready),
    .op_i               (req_op),
    .priority_req_i     (req_prio),
    .tag_i              (req_tag),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .removed_valid_o    (removed_valid),
    .removed_priority_o (removed_priority),
    .removed_tag_o      (removed_tag),
    .head_valid_o       (head_valid),
    .head_priority_o    (head_priority),
    .head_tag_o         (head_tag),
    .count_o            (count),
    .overflow_o         (overflow)
  );

  spq_order_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (req_valid),
    .in_ready_i         (in_ready),
    .op_i               (req_op),
    .priority_req_i     (req_prio),
    .tag_i              (req_tag),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .removed_valid_i    (removed_valid),
    .removed_priority_i (removed_priority),
    .removed_tag_i      (removed_tag),
    .head_valid_i       (head_valid),
    .head_priority_i    (head_priority),
    .head_tag_i         (head_tag),
    .count_i            (count),
    .overflow_i         (overflow),
    .errors_o           (errors),
    .outstanding_o      (outstanding)
  );

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if ((req_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One request. Called and returns at a falling edge; valid is left high
  // afterwards so that back-to-back requests never drop it in between.
  task automatic push_request(input spq_op_e kind, input logic [SpqPrioBits-1:0] prio,
                              input logic [SpqTagBits-1:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= kind;
    req_prio  <= prio;
    req_tag   <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Bias towards few values so that ties are common, plus both extremes.
  function automatic logic [SpqPrioBits-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return SpqPrioBits'($urandom_range(3));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return SpqPrioBits'($urandom);
    endcase
  endfunction

  // Random part: runs of inserts to overflow, runs of removes past empty,
  // and mixed walks with an insert bias that drifts around.
  task automatic run_random(input int n);
    int sent;
    int kind;
    int run_len;
    int insert_pct;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        run_len    = SpqDepth + 2;
        insert_pct = 100;
      end else if (kind < 4) begin
        run_len    = SpqDepth + 2;
        insert_pct = 0;
      end else begin
        run_len    = $urandom_range(8, 32);
        insert_pct = 25 * $urandom_range(1, 3);
      end
      repeat (run_len) begin
        push_request(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                     pick_priority(), SpqTagBits'($urandom_range(16'hffff)));
        sent++;
      end
    end
  endtask

  // Sender holds off until the checker has nothing left outstanding.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    run_random(RandomPerPhase);
    wait_drained();
  endtask

  initial begin
    req_valid      = 1'b0;
    req_op         = OP_INSERT;
    req_prio       = '0;
    req_tag        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_cycles   = 0;
    rst_n          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: remove on empty, extremes, ties at top and middle, drain past empty
    push_request(OP_REMOVE, '0, '0);
    push_request(OP_INSERT, 8'hff, 16'hffff);
    push_request(OP_INSERT, 8'h00, 16'h0000);
    push_request(OP_INSERT, 8'h80, 16'h00aa);
    push_request(OP_INSERT, 8'h80, 16'h00bb);
    push_request(OP_INSERT, 8'h80, 16'h00cc);
    push_request(OP_INSERT, 8'hff, 16'h1234);
    push_request(OP_INSERT, 8'h00, 16'h8001);
    repeat (8) push_request(OP_REMOVE, 8'h5a, 16'ha5a5);
    wait_drained();

    run_phase(0, 0);
    run_phase(62, 0);
    run_phase(0, 62);
    run_phase(36, 36);

    // spare edges at the end catch any stray result
    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
